>>> hdl/dvfsgov_pkg.sv
// ----------------------------------------------------------------------------
// dvfsgov_pkg
// Shared types and constants of the beta-adaptation frequency governor.
// ----------------------------------------------------------------------------
package dvfsgov_pkg;

    localparam logic        OP_TABLE = 1'b0;
    localparam logic        OP_TICK  = 1'b1;

    localparam logic [2:0]  REG_STRATEGY    = 3'd0;
    localparam logic [2:0]  REG_FREQ_COUNT  = 3'd1;
    localparam logic [2:0]  REG_EVAL_WINDOW = 3'd2;
    localparam logic [2:0]  REG_SWITCH_LAT  = 3'd3;
    localparam logic [2:0]  REG_DEGRADATION = 3'd4;

    localparam logic [1:0]  STRAT_MIPS_EXT = 2'd0;
    localparam logic [1:0]  STRAT_VIRT_ADJ = 2'd1;
    localparam logic [1:0]  STRAT_MAX_HIGH = 2'd2;
    localparam logic [1:0]  STRAT_MIN_LOW  = 2'd3;

    localparam logic [1:0]  RST_STRATEGY    = 2'd1;
    localparam logic [4:0]  RST_FREQ_COUNT  = 5'd8;
    localparam logic [15:0] RST_EVAL_WINDOW = 16'd100;
    localparam logic [23:0] RST_SWITCH_LAT  = 24'd0;
    localparam logic [15:0] RST_DEGRADATION = 16'd3277;

    localparam logic [16:0] ONE_Q16       = 17'h10000;
    localparam logic [23:0] RATIO_SAT     = 24'hFFFFFF;
    localparam logic [31:0] K_SAT         = 32'hFFFFFFFF;
    localparam logic [23:0] MIPS_MIN_INIT = 24'd6553600;

    // x / 1000 = (x >> 3) / 125, reciprocal of 125 in Q0.28
    localparam logic [21:0] RECIP_125     = 22'd2147484;
    localparam int          RECIP_SHIFT   = 28;

    typedef struct packed {
        logic [1:0]  strategy;
        logic [4:0]  freq_count;
        logic [15:0] eval_window;
        logic [15:0] degradation;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [3:0]  freq_index;
        logic [21:0] freq_khz;
        logic [23:0] mips_rate;
        logic        delayed_start;
    } item_t;

    typedef struct packed {
        logic [3:0]  freq_id;
        logic [15:0] sleep_win;
        logic        dly;
    } res_t;

    typedef struct packed {
        logic        start;
        logic        mul;
        logic [63:0] a;
        logic [63:0] b;
    } arith_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } arith_rsp_t;

    function automatic logic [23:0] sat24(input logic [63:0] q);
        return (q > 64'(RATIO_SAT)) ? RATIO_SAT : q[23:0];
    endfunction

endpackage

>>> hdl/dvfsgov_ram.sv
// ----------------------------------------------------------------------------
// dvfsgov_ram
// Single-port-write, single-port-read synchronous table with a registered read.
// ----------------------------------------------------------------------------
module dvfsgov_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/dvfsgov_arith.sv
// ----------------------------------------------------------------------------
// dvfsgov_arith
// Shared serial unit: shift-add multiply and restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module dvfsgov_arith (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dvfsgov_pkg::arith_req_t req,
    output dvfsgov_pkg::arith_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mul_reg, mul_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] opa_reg, opa_next;
    logic [63:0] opb_reg, opb_next;
    logic [63:0] rem_reg, rem_next;
    logic [64:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, opa_reg[63]};
    assign ge     = rem_sh >= {1'b0, opb_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mul_next  = mul_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            mul_next  = req.mul;
            cnt_next  = '0;
            acc_next  = '0;
            opa_next  = req.a;
            opb_next  = req.b;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (mul_reg)
            begin
                if (opb_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    if (opb_reg[0])
                    begin
                        acc_next = acc_reg + opa_reg;
                    end
                    opa_next = {opa_reg[62:0], 1'b0};
                    opb_next = {1'b0, opb_reg[63:1]};
                end
            end
            else
            begin
                rem_next = ge ? 64'(rem_sh - {1'b0, opb_reg}) : rem_sh[63:0];
                acc_next = {acc_reg[62:0], ge};
                opa_next = {opa_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

>>> hdl/dvfsgov_core.sv
// ----------------------------------------------------------------------------
// dvfsgov_core
// Decision sequencer: table updates, beta fit, virtual frequency, pair pick
// and window split, around the frequency and MIPS tables.
// ----------------------------------------------------------------------------
module dvfsgov_core #(
    parameter int MAX_FREQS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dvfsgov_pkg::cfg_t  cfg,
    input  logic               start,
    input  dvfsgov_pkg::item_t item,
    output logic               ready,
    output logic               res_valid,
    input  logic               res_take,
    output dvfsgov_pkg::res_t  res
);

    localparam int AW = (MAX_FREQS > 2) ? $clog2(MAX_FREQS) : 1;

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_EVAL   = 2'd1;
    localparam logic [1:0] PH_FIRST  = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RES     = 5'd1;
    localparam logic [4:0] ST_TOP_RD  = 5'd2;
    localparam logic [4:0] ST_TOP_CAP = 5'd3;
    localparam logic [4:0] ST_L_RD    = 5'd4;
    localparam logic [4:0] ST_L_CAP   = 5'd5;
    localparam logic [4:0] ST_L_XW    = 5'd6;
    localparam logic [4:0] ST_L_YW    = 5'd7;
    localparam logic [4:0] ST_L_M1    = 5'd8;
    localparam logic [4:0] ST_L_M2    = 5'd9;
    localparam logic [4:0] ST_L_ACC   = 5'd10;
    localparam logic [4:0] ST_K0      = 5'd11;
    localparam logic [4:0] ST_K1      = 5'd12;
    localparam logic [4:0] ST_K2      = 5'd13;
    localparam logic [4:0] ST_V0      = 5'd14;
    localparam logic [4:0] ST_V1      = 5'd15;
    localparam logic [4:0] ST_S_RD    = 5'd16;
    localparam logic [4:0] ST_S_CK    = 5'd17;
    localparam logic [4:0] ST_PICK    = 5'd18;
    localparam logic [4:0] ST_FL_CAP  = 5'd19;
    localparam logic [4:0] ST_FH_CAP  = 5'd20;
    localparam logic [4:0] ST_A0      = 5'd21;
    localparam logic [4:0] ST_A1      = 5'd22;
    localparam logic [4:0] ST_A2      = 5'd23;
    localparam logic [4:0] ST_A3      = 5'd24;
    localparam logic [4:0] ST_A4      = 5'd25;
    localparam logic [4:0] ST_A5      = 5'd26;
    localparam logic [4:0] ST_FIN1    = 5'd27;
    localparam logic [4:0] ST_FIN2    = 5'd28;

    logic [4:0]         state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [AW-1:0]      second_id_reg, second_id_next;
    logic [15:0]        second_sleep_reg, second_sleep_next;
    logic [AW-1:0]      res_id_reg, res_id_next;
    logic [15:0]        res_sleep_reg, res_sleep_next;
    logic               res_dly_reg, res_dly_next;

    logic [AW-1:0]      i_reg, i_next;
    logic [21:0]        fmax_reg, fmax_next;
    logic [23:0]        mmax_reg, mmax_next;
    logic [21:0]        fmin_reg, fmin_next;
    logic [23:0]        mi_reg, mi_next;
    logic signed [24:0] x_reg, x_next;
    logic signed [24:0] y_reg, y_next;
    logic signed [49:0] p_reg, p_next;
    logic signed [63:0] num_reg, num_next;
    logic [63:0]        den_reg, den_next;
    logic [31:0]        k_reg, k_next;
    logic [21:0]        virt_reg, virt_next;
    logic [23:0]        mn_reg, mn_next;
    logic [23:0]        mx_reg, mx_next;
    logic [AW-1:0]      lo_min_reg, lo_min_next;
    logic [AW-1:0]      hi_max_reg, hi_max_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      fa_reg, fa_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [21:0]        fl_reg, fl_next;
    logic [21:0]        fh_reg, fh_next;
    logic [53:0]        a_reg, a_next;
    logic [43:0]        d_reg, d_next;
    logic [16:0]        r_reg, r_next;

    logic [AW-1:0]      n_last;
    logic               fq_we;
    logic [AW-1:0]      fq_waddr;
    logic               mp_we;
    logic [AW-1:0]      raddr;
    logic [21:0]        fq_rd;
    logic [23:0]        mp_rd;

    dvfsgov_pkg::arith_req_t arq;
    dvfsgov_pkg::arith_rsp_t ars;

    logic signed [24:0] mul_b;
    logic signed [49:0] mul_p;
    logic [16:0]        fin_r;
    logic [32:0]        fin_p;
    logic [64:0]        ksum;
    logic [63:0]        fmx16;
    logic [21:0]        vq;
    logic [AW-1:0]      pick_lo, pick_hi, pick_t;

    always_comb
    begin
        if (cfg.freq_count < 5'd2)
        begin
            n_last = AW'(1);
        end
        else if (32'(cfg.freq_count) > MAX_FREQS)
        begin
            n_last = AW'(MAX_FREQS - 1);
        end
        else
        begin
            n_last = AW'(cfg.freq_count - 5'd1);
        end
    end

    assign fq_waddr = AW'(item.freq_index);
    assign fq_we    = start && (state_reg == ST_IDLE) && (item.op == dvfsgov_pkg::OP_TABLE)
                      && (32'(item.freq_index) < MAX_FREQS);
    assign mp_we    = start && (state_reg == ST_IDLE) && (item.op == dvfsgov_pkg::OP_TICK)
                      && !item.delayed_start
                      && ((phase_reg == PH_EVAL) || (phase_reg == PH_SECOND)
                          || ((phase_reg == PH_FIRST) && (cfg.eval_window != 16'd0)));

    dvfsgov_ram #(.WIDTH(22), .DEPTH(MAX_FREQS), .AW(AW)) u_freq_ram (
        .clk   (clk),
        .we    (fq_we),
        .waddr (fq_waddr),
        .wdata (item.freq_khz),
        .raddr (raddr),
        .rdata (fq_rd)
    );

    dvfsgov_ram #(.WIDTH(24), .DEPTH(MAX_FREQS), .AW(AW)) u_mips_ram (
        .clk   (clk),
        .we    (mp_we),
        .waddr (last_reg),
        .wdata (item.mips_rate),
        .raddr (raddr),
        .rdata (mp_rd)
    );

    dvfsgov_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arq),
        .rsp   (ars)
    );

    // pair selection per strategy
    always_comb
    begin
        pick_t = found_reg ? fa_reg : '0;
        case (cfg.strategy)
            dvfsgov_pkg::STRAT_MIPS_EXT:
            begin
                pick_lo = lo_min_reg;
                pick_hi = hi_max_reg;
            end
            dvfsgov_pkg::STRAT_VIRT_ADJ:
            begin
                pick_hi = found_reg ? fa_reg : n_last;
                pick_lo = (pick_hi != '0) ? pick_hi - AW'(1) : '0;
            end
            dvfsgov_pkg::STRAT_MAX_HIGH:
            begin
                pick_hi = hi_max_reg;
                pick_lo = (pick_t != '0) ? pick_t - AW'(1) : '0;
            end
            dvfsgov_pkg::STRAT_MIN_LOW:
            begin
                pick_lo = lo_min_reg;
                pick_hi = found_reg ? fa_reg : n_last;
            end
            default:
            begin
                pick_lo = '0;
                pick_hi = '0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_TOP_RD: raddr = n_last;
            ST_PICK:   raddr = pick_lo;
            ST_FL_CAP: raddr = hi_reg;
            default:   raddr = i_reg;
        endcase
    end

    assign mul_b = (state_reg == ST_L_M1) ? y_reg : x_reg;
    assign mul_p = x_reg * mul_b;
    assign fin_r = (state_reg == ST_FIN1) ? r_reg : 17'(dvfsgov_pkg::ONE_Q16 - r_reg);
    assign fin_p = 33'(fin_r) * 33'(cfg.eval_window);
    assign ksum  = {1'b0, ars.result} + 65'(dvfsgov_pkg::ONE_Q16);
    assign fmx16 = 64'({fmax_reg, 16'h0000});
    assign vq    = ars.result[21:0];

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        last_next         = last_reg;
        second_id_next    = second_id_reg;
        second_sleep_next = second_sleep_reg;
        res_id_next       = res_id_reg;
        res_sleep_next    = res_sleep_reg;
        res_dly_next      = res_dly_reg;
        i_next            = i_reg;
        fmax_next         = fmax_reg;
        mmax_next         = mmax_reg;
        fmin_next         = fmin_reg;
        mi_next           = mi_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        p_next            = p_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        k_next            = k_reg;
        virt_next         = virt_reg;
        mn_next           = mn_reg;
        mx_next           = mx_reg;
        lo_min_next       = lo_min_reg;
        hi_max_next       = hi_max_reg;
        found_next        = found_reg;
        fa_next           = fa_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        fl_next           = fl_reg;
        fh_next           = fh_reg;
        a_next            = a_reg;
        d_next            = d_reg;
        r_next            = r_reg;
        arq               = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start && (item.op == dvfsgov_pkg::OP_TICK))
                begin
                    res_dly_next   = 1'b0;
                    res_id_next    = '0;
                    res_sleep_next = cfg.eval_window;
                    if (item.delayed_start)
                    begin
                        res_dly_next = 1'b1;
                        state_next   = ST_RES;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_WAIT:
                            begin
                                phase_next = PH_EVAL;
                                last_next  = '0;
                                state_next = ST_RES;
                            end
                            PH_EVAL:
                            begin
                                if (last_reg < n_last)
                                begin
                                    res_id_next = last_reg + AW'(1);
                                    last_next   = last_reg + AW'(1);
                                    state_next  = ST_RES;
                                end
                                else
                                begin
                                    state_next = ST_TOP_RD;
                                end
                            end
                            PH_FIRST:
                            begin
                                if (second_sleep_reg == 16'd0)
                                begin
                                    state_next = ST_TOP_RD;
                                end
                                else
                                begin
                                    phase_next     = PH_SECOND;
                                    res_id_next    = second_id_reg;
                                    res_sleep_next = second_sleep_reg;
                                    last_next      = second_id_reg;
                                    state_next     = ST_RES;
                                end
                            end
                            default:
                            begin
                                state_next = ST_TOP_RD;
                            end
                        endcase
                    end
                end
            end
            ST_RES:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TOP_RD:
            begin
                num_next   = '0;
                den_next   = '0;
                i_next     = '0;
                state_next = ST_TOP_CAP;
            end
            ST_TOP_CAP:
            begin
                fmax_next  = fq_rd;
                mmax_next  = mp_rd;
                state_next = ST_L_RD;
            end
            ST_L_RD:
            begin
                state_next = ST_L_CAP;
            end
            ST_L_CAP:
            begin
                mi_next = mp_rd;
                if (i_reg == '0)
                begin
                    fmin_next = fq_rd;
                end
                arq.start  = 1'b1;
                arq.a      = fmx16;
                arq.b      = 64'(fq_rd);
                state_next = ST_L_XW;
            end
            ST_L_XW:
            begin
                if (ars.done)
                begin
                    x_next     = $signed({1'b0, dvfsgov_pkg::sat24(ars.result)}) - 25'sd65536;
                    arq.start  = 1'b1;
                    arq.a      = 64'({mmax_reg, 16'h0000});
                    arq.b      = 64'(mi_reg);
                    state_next = ST_L_YW;
                end
            end
            ST_L_YW:
            begin
                if (ars.done)
                begin
                    y_next     = $signed({1'b0, dvfsgov_pkg::sat24(ars.result)}) - 25'sd65536;
                    state_next = ST_L_M1;
                end
            end
            ST_L_M1:
            begin
                p_next     = mul_p;
                state_next = ST_L_M2;
            end
            ST_L_M2:
            begin
                num_next   = num_reg + 64'(p_reg);
                p_next     = mul_p;
                state_next = ST_L_ACC;
            end
            ST_L_ACC:
            begin
                den_next = den_reg + 64'(p_reg);
                if (i_reg == n_last)
                begin
                    state_next = ST_K0;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_L_RD;
                end
            end
            ST_K0:
            begin
                // beta not positive, or num[62:16] zero: k saturates
                if (num_reg[63] || (num_reg[62:16] == '0))
                begin
                    k_next     = dvfsgov_pkg::K_SAT;
                    state_next = ST_V0;
                end
                else
                begin
                    arq.start  = 1'b1;
                    arq.mul    = 1'b1;
                    arq.a      = 64'(den_reg[63:16]);
                    arq.b      = 64'(cfg.degradation);
                    state_next = ST_K1;
                end
            end
            ST_K1:
            begin
                if (ars.done)
                begin
                    arq.start  = 1'b1;
                    arq.a      = ars.result;
                    arq.b      = 64'(num_reg[63:16]);
                    state_next = ST_K2;
                end
            end
            ST_K2:
            begin
                if (ars.done)
                begin
                    k_next     = (ksum > 65'(dvfsgov_pkg::K_SAT)) ? dvfsgov_pkg::K_SAT
                                                                  : ksum[31:0];
                    state_next = ST_V0;
                end
            end
            ST_V0:
            begin
                arq.start  = 1'b1;
                arq.a      = fmx16;
                arq.b      = 64'(k_reg);
                state_next = ST_V1;
            end
            ST_V1:
            begin
                if (ars.done)
                begin
                    virt_next   = (vq < fmin_reg) ? fmin_reg : vq;
                    i_next      = '0;
                    mn_next     = dvfsgov_pkg::MIPS_MIN_INIT;
                    mx_next     = '0;
                    lo_min_next = '0;
                    hi_max_next = (cfg.strategy == dvfsgov_pkg::STRAT_MAX_HIGH) ? n_last : '0;
                    found_next  = 1'b0;
                    fa_next     = '0;
                    state_next  = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                state_next = ST_S_CK;
            end
            ST_S_CK:
            begin
                if (mn_reg > mp_rd)
                begin
                    mn_next     = mp_rd;
                    lo_min_next = i_reg;
                end
                if (mx_reg < mp_rd)
                begin
                    mx_next     = mp_rd;
                    hi_max_next = i_reg;
                end
                if (!found_reg && (fq_rd > virt_reg))
                begin
                    found_next = 1'b1;
                    fa_next    = i_reg;
                end
                if (i_reg == n_last)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_PICK:
            begin
                lo_next    = pick_lo;
                hi_next    = pick_hi;
                state_next = ST_FL_CAP;
            end
            ST_FL_CAP:
            begin
                fl_next    = fq_rd;
                state_next = ST_FH_CAP;
            end
            ST_FH_CAP:
            begin
                fh_next    = fq_rd;
                state_next = ST_A0;
            end
            ST_A0:
            begin
                arq.start  = 1'b1;
                arq.mul    = 1'b1;
                arq.a      = 64'(k_reg);
                arq.b      = 64'(fh_reg);
                state_next = ST_A1;
            end
            ST_A1:
            begin
                if (ars.done)
                begin
                    if ((ars.result <= fmx16) || (fl_reg == '0))
                    begin
                        r_next     = '0;
                        state_next = ST_FIN1;
                    end
                    else if ((fh_reg <= fl_reg) || (fmax_reg == '0))
                    begin
                        r_next     = dvfsgov_pkg::ONE_Q16;
                        state_next = ST_FIN1;
                    end
                    else
                    begin
                        a_next     = 54'(ars.result - fmx16);
                        arq.start  = 1'b1;
                        arq.mul    = 1'b1;
                        arq.a      = 64'(fmax_reg);
                        arq.b      = 64'(fh_reg - fl_reg);
                        state_next = ST_A2;
                    end
                end
            end
            ST_A2:
            begin
                if (ars.done)
                begin
                    d_next     = ars.result[43:0];
                    arq.start  = 1'b1;
                    arq.a      = 64'({ars.result[43:0], 16'h0000});
                    arq.b      = 64'(fl_reg);
                    state_next = ST_A3;
                end
            end
            ST_A3:
            begin
                if (ars.done)
                begin
                    if (64'(a_reg) > ars.result)
                    begin
                        r_next     = dvfsgov_pkg::ONE_Q16;
                        state_next = ST_FIN1;
                    end
                    else
                    begin
                        arq.start  = 1'b1;
                        arq.mul    = 1'b1;
                        arq.a      = 64'(a_reg);
                        arq.b      = 64'(fl_reg);
                        state_next = ST_A4;
                    end
                end
            end
            ST_A4:
            begin
                if (ars.done)
                begin
                    arq.start  = 1'b1;
                    arq.a      = ars.result;
                    arq.b      = 64'(d_reg);
                    state_next = ST_A5;
                end
            end
            ST_A5:
            begin
                if (ars.done)
                begin
                    r_next     = (ars.result > 64'(dvfsgov_pkg::ONE_Q16))
                                 ? dvfsgov_pkg::ONE_Q16 : ars.result[16:0];
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1:
            begin
                res_sleep_next = fin_p[31:16];
                state_next     = ST_FIN2;
            end
            ST_FIN2:
            begin
                second_sleep_next = fin_p[31:16];
                second_id_next    = hi_reg;
                res_id_next       = lo_reg;
                last_next         = lo_reg;
                res_dly_next      = 1'b0;
                phase_next        = PH_FIRST;
                state_next        = ST_RES;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_WAIT;
            last_reg         <= '0;
            second_id_reg    <= '0;
            second_sleep_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            last_reg         <= last_next;
            second_id_reg    <= second_id_next;
            second_sleep_reg <= second_sleep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_id_reg    <= res_id_next;
        res_sleep_reg <= res_sleep_next;
        res_dly_reg   <= res_dly_next;
        i_reg         <= i_next;
        fmax_reg      <= fmax_next;
        mmax_reg      <= mmax_next;
        fmin_reg      <= fmin_next;
        mi_reg        <= mi_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        p_reg         <= p_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        k_reg         <= k_next;
        virt_reg      <= virt_next;
        mn_reg        <= mn_next;
        mx_reg        <= mx_next;
        lo_min_reg    <= lo_min_next;
        hi_max_reg    <= hi_max_next;
        found_reg     <= found_next;
        fa_reg        <= fa_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        fl_reg        <= fl_next;
        fh_reg        <= fh_next;
        a_reg         <= a_next;
        d_reg         <= d_next;
        r_reg         <= r_next;
    end

    assign ready         = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_RES);
    assign res.freq_id   = 4'(res_id_reg);
    assign res.sleep_win = res_sleep_reg;
    assign res.dly       = res_dly_reg;

`ifndef SYNTH
    a_arith_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        arq.start |-> !ars.busy)
        else $error("arith unit started while busy");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_take |=> res_valid && $stable(res_id_reg) && $stable(res_sleep_reg))
        else $error("pending result lost or changed");

    a_k_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_V0) |-> (k_reg >= 32'(dvfsgov_pkg::ONE_Q16)))
        else $error("k below one");

    a_r_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN1) |-> (r_reg <= dvfsgov_pkg::ONE_Q16))
        else $error("split ratio above one");

    a_wait_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (last_reg == '0))
        else $error("frequency index moved before start");
`endif

endmodule

>>> hdl/dvfs_beta_frequency_governor_top.sv
// ----------------------------------------------------------------------------
// dvfs_beta_frequency_governor_top
// Beta-adaptation DVFS governor: configuration registers, item handshake and
// output register around the decision sequencer.
// ----------------------------------------------------------------------------
// A table write (op 0) is stored when accepted and gives no result. A decision
// tick gives one result: a delayed-start tick, a start tick, an evaluation
// step and a first-half step without refit go straight to the result state
// and from there to the output register. A tick that refits runs the beta
// fit over freq_count entries, clamped to 2..MAX_FREQS, through one shared
// serial divider (two divides per entry) and the table memories. One item is
// in work at a time; the output register lets the next item in while a
// result waits.
module dvfs_beta_frequency_governor_top #(
    parameter int MAX_FREQS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [3:0]  freq_index,
    input  logic [21:0] freq_khz,
    input  logic [23:0] mips_rate,
    input  logic        delayed_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  freq_id,
    output logic [15:0] sleep_win,
    output logic [14:0] pre_pause,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic [1:0]  strategy_reg, strategy_next;
    logic [4:0]  freq_count_reg, freq_count_next;
    logic [15:0] eval_window_reg, eval_window_next;
    logic [23:0] switch_lat_reg, switch_lat_next;
    logic [15:0] degradation_reg, degradation_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  freq_id_reg, freq_id_next;
    logic [15:0] sleep_win_reg, sleep_win_next;
    logic [14:0] pre_pause_reg, pre_pause_next;

    dvfsgov_pkg::cfg_t  cfg;
    dvfsgov_pkg::item_t item;
    dvfsgov_pkg::res_t  res;
    logic               core_ready;
    logic               res_valid;
    logic               res_take;
    logic               accept;
    logic [42:0]        pause_p;

    assign cfg_ready = 1'b1;
    assign in_stall  = !core_ready;
    assign accept    = in_valid && !in_stall;

    assign cfg.strategy    = strategy_reg;
    assign cfg.freq_count  = freq_count_reg;
    assign cfg.eval_window = eval_window_reg;
    assign cfg.degradation = degradation_reg;

    assign item.op            = op;
    assign item.freq_index    = freq_index;
    assign item.freq_khz      = freq_khz;
    assign item.mips_rate     = mips_rate;
    assign item.delayed_start = delayed_start;

    always_comb
    begin
        strategy_next    = strategy_reg;
        freq_count_next  = freq_count_reg;
        eval_window_next = eval_window_reg;
        switch_lat_next  = switch_lat_reg;
        degradation_next = degradation_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dvfsgov_pkg::REG_STRATEGY:    strategy_next    = cfg_data[1:0];
                dvfsgov_pkg::REG_FREQ_COUNT:  freq_count_next  = cfg_data[4:0];
                dvfsgov_pkg::REG_EVAL_WINDOW: eval_window_next = cfg_data[15:0];
                dvfsgov_pkg::REG_SWITCH_LAT:  switch_lat_next  = cfg_data;
                dvfsgov_pkg::REG_DEGRADATION: degradation_next = cfg_data[15:0];
                default:                      strategy_next    = strategy_reg;
            endcase
        end
    end

    dvfsgov_core #(.MAX_FREQS(MAX_FREQS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (accept),
        .item      (item),
        .ready     (core_ready),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // switch_lat_reg / 1000, by reciprocal multiply
    assign pause_p  = 43'(switch_lat_reg[23:3]) * 43'(dvfsgov_pkg::RECIP_125);
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        freq_id_next   = freq_id_reg;
        sleep_win_next = sleep_win_reg;
        pre_pause_next = pre_pause_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            freq_id_next   = res.freq_id;
            sleep_win_next = res.sleep_win;
            pre_pause_next = res.dly ? 15'd0
                                     : pause_p[dvfsgov_pkg::RECIP_SHIFT +: 15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg    <= dvfsgov_pkg::RST_STRATEGY;
            freq_count_reg  <= dvfsgov_pkg::RST_FREQ_COUNT;
            eval_window_reg <= dvfsgov_pkg::RST_EVAL_WINDOW;
            switch_lat_reg  <= dvfsgov_pkg::RST_SWITCH_LAT;
            degradation_reg <= dvfsgov_pkg::RST_DEGRADATION;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            strategy_reg    <= strategy_next;
            freq_count_reg  <= freq_count_next;
            eval_window_reg <= eval_window_next;
            switch_lat_reg  <= switch_lat_next;
            degradation_reg <= degradation_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_id_reg   <= freq_id_next;
        sleep_win_reg <= sleep_win_next;
        pre_pause_reg <= pre_pause_next;
    end

    assign out_valid = out_valid_reg;
    assign freq_id   = freq_id_reg;
    assign sleep_win = sleep_win_reg;
    assign pre_pause = pre_pause_reg;

endmodule
